// File: sv/dfal_pkg.sv
// dfal_pkg: shared types, codes and defaults for the dynamic forest adjacency lists
// block. No dependencies. Used by every module of the block and by its checker.
package dfal_pkg;

   // default sizes, handed to the top level parameters
   localparam int DEF_MAX_NODES = 64;
   localparam int DEF_MAX_EDGES = 128;

   // csr port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_COUNT = 4'd1;

   localparam logic [6:0] NODE_COUNT_RST = 7'd64;
   localparam logic [7:0] EDGE_COUNT_RST = 8'd128;

   // request function codes
   localparam logic [2:0] FN_DEFINE   = 3'd0;
   localparam logic [2:0] FN_LINK     = 3'd1;
   localparam logic [2:0] FN_CUT      = 3'd2;
   localparam logic [2:0] FN_CONTAINS = 3'd3;
   localparam logic [2:0] FN_FIRST    = 3'd4;
   localparam logic [2:0] FN_NEXT     = 3'd5;
   localparam logic [2:0] FN_OTHER    = 3'd6;

   // response status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_RANGE    = 3'd1;
   localparam logic [2:0] ST_LINKED   = 3'd2;
   localparam logic [2:0] ST_UNLINKED = 3'd3;
   localparam logic [2:0] ST_BADEDGE  = 3'd4;

   typedef struct packed {
      logic [2:0] func;
      logic [6:0] edge_index;
      logic [5:0] tail_node;
      logic [5:0] head_node;
      logic [5:0] node_index;
      logic [7:0] slot_index;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] status;
      logic       is_present;
      logic [7:0] slot_value;
      logic       slot_none;
      logic [5:0] endpoint;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_PUSH_RD,
      ST_PUSH_WR,
      ST_PUSH_FIX,
      ST_CUT_RD,
      ST_CUT_WR,
      ST_CUT_CLR,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CLEAR,
      OP_LATCH,
      OP_READ,
      OP_EVAL,
      OP_PUSH_RD,
      OP_PUSH_WR,
      OP_PUSH_FIX,
      OP_CUT_RD,
      OP_CUT_WR,
      OP_CUT_CLR,
      OP_RESULT
   } dp_op_type;

   // controller to datapath
   typedef struct packed {
      dp_op_type op;
      logic      sel;   // 0 tail end slot, 1 head end slot
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic go_link;
      logic go_cut;
      logic rsp_free;
   } dp_stat_type;

endpackage

// File: sv/dfal_ctrl.sv
// dfal_ctrl: sequencer for the adjacency list block, one request at a time.
// Depends on dfal_pkg; drives dfal_datapath through dp_cmd_type.
module dfal_ctrl
   import dfal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      cmd.op    = OP_NOP;
      cmd.sel   = sel_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.op   = OP_READ;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.op = OP_EVAL;
            sel_in = 1'b0;
            priority if (stat.go_link) begin
               state_in = ST_PUSH_RD;
            end else if (stat.go_cut) begin
               state_in = ST_CUT_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PUSH_RD: begin
            cmd.op   = OP_PUSH_RD;
            state_in = ST_PUSH_WR;
         end
         ST_PUSH_WR: begin
            cmd.op   = OP_PUSH_WR;
            state_in = ST_PUSH_FIX;
         end
         ST_PUSH_FIX: begin
            cmd.op = OP_PUSH_FIX;
            if (sel_ff) begin
               state_in = ST_DONE;
            end else begin
               sel_in   = 1'b1;
               state_in = ST_PUSH_RD;
            end
         end
         ST_CUT_RD: begin
            cmd.op   = OP_CUT_RD;
            state_in = ST_CUT_WR;
         end
         ST_CUT_WR: begin
            cmd.op   = OP_CUT_WR;
            state_in = ST_CUT_CLR;
         end
         ST_CUT_CLR: begin
            cmd.op = OP_CUT_CLR;
            if (sel_ff) begin
               state_in = ST_DONE;
            end else begin
               sel_in   = 1'b1;
               state_in = ST_CUT_RD;
            end
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.op   = OP_RESULT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: sv/dfal_datapath.sv
// dfal_datapath: edge tables, list memories, csr registers, checks and result register.
// Depends on dfal_pkg; sequenced by dfal_ctrl through dp_cmd_type.
module dfal_datapath
   import dfal_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES,
   parameter int MAX_EDGES = DEF_MAX_EDGES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   input  req_payload_type       req_payload,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload
);

   localparam int EW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int SW    = EW + 1;
   localparam int PW    = SW + 1;   // msb flags the empty sentinel
   localparam int NW    = $clog2(MAX_NODES);
   localparam int SLOTS = 2 * MAX_EDGES;
   localparam int CLR_N = (MAX_NODES > SLOTS) ? MAX_NODES : SLOTS;
   localparam int CLW   = $clog2(CLR_N);
   localparam logic [PW-1:0] NONE_PTR = PW'(1) << SW;

   // memories
   logic [NW-1:0] tail_mem  [MAX_EDGES];
   logic [NW-1:0] head_mem  [MAX_EDGES];
   logic          inf_mem   [MAX_EDGES];
   logic [PW-1:0] lhead_mem [MAX_NODES];
   logic [PW-1:0] next_mem  [SLOTS];
   logic [PW-1:0] prev_mem  [SLOTS];

   // registers
   req_payload_type req_ff;
   rsp_payload_type res_ff, rsp_payload_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [6:0]      node_count_ff, node_count_in;
   logic [7:0]      edge_count_ff, edge_count_in;
   logic [CLW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [NW-1:0]   tail_rd_ff, head_rd_ff;
   logic            inf_rd_ff;
   logic [PW-1:0]   lh_rd_ff, nx_rd_ff, pv_rd_ff;

   // comb
   rsp_payload_type res_in;
   logic            define_ok;
   logic [EW-1:0]   edge_a, slot_edge;
   logic [SW-1:0]   slot_cur;
   logic [PW-1:0]   slot_ptr, ans_ptr;
   logic [NW-1:0]   owner;
   logic            edge_ok, slot_ok, node_ok, tail_ok, head_ok;
   logic            clr_node_ok, clr_edge_ok, clr_slot_ok;

   logic            th_re, th_we;
   logic [EW-1:0]   th_ra;
   logic            inf_we, inf_wd;
   logic [EW-1:0]   inf_wa;
   logic            lh_re, lh_we;
   logic [NW-1:0]   lh_ra, lh_wa;
   logic [PW-1:0]   lh_wd;
   logic            nx_re, nx_we;
   logic [SW-1:0]   nx_ra, nx_wa;
   logic [PW-1:0]   nx_wd;
   logic            pv_we;
   logic [SW-1:0]   pv_wa;
   logic [PW-1:0]   pv_wd;

   assign edge_a    = EW'(req_ff.edge_index);
   assign slot_edge = EW'(req_ff.slot_index[7:1]);
   assign slot_cur  = {edge_a, cmd.sel};
   assign slot_ptr  = {1'b0, slot_cur};
   assign owner     = cmd.sel ? head_rd_ff : tail_rd_ff;

   // index checks against the live counts and the built-in sizes
   assign edge_ok = ({1'b0, req_ff.edge_index} < edge_count_ff)
                    && (32'(req_ff.edge_index) < MAX_EDGES);
   assign slot_ok = ({1'b0, req_ff.slot_index[7:1]} < edge_count_ff)
                    && (32'(req_ff.slot_index[7:1]) < MAX_EDGES);
   assign node_ok = ({1'b0, req_ff.node_index} < node_count_ff)
                    && (32'(req_ff.node_index) < MAX_NODES);
   assign tail_ok = ({1'b0, req_ff.tail_node} < node_count_ff)
                    && (32'(req_ff.tail_node) < MAX_NODES);
   assign head_ok = ({1'b0, req_ff.head_node} < node_count_ff)
                    && (32'(req_ff.head_node) < MAX_NODES);

   assign clr_node_ok = 32'(clr_cnt_ff) < MAX_NODES;
   assign clr_edge_ok = 32'(clr_cnt_ff) < MAX_EDGES;
   assign clr_slot_ok = 32'(clr_cnt_ff) < SLOTS;

   assign ans_ptr = (req_ff.func == FN_FIRST) ? lh_rd_ff : nx_rd_ff;

   // result of the checks and of the single-read queries
   always_comb begin
      res_in    = '0;
      define_ok = 1'b0;
      unique case (req_ff.func)
         FN_DEFINE: begin
            priority if (!edge_ok) begin
               res_in.status = ST_RANGE;
            end else if (!tail_ok || !head_ok || req_ff.tail_node == req_ff.head_node) begin
               res_in.status = ST_BADEDGE;
            end else if (inf_rd_ff) begin
               res_in.status = ST_LINKED;
            end else begin
               define_ok = 1'b1;
            end
         end
         FN_LINK: begin
            priority if (!edge_ok) begin
               res_in.status = ST_RANGE;
            end else if (inf_rd_ff) begin
               res_in.status = ST_LINKED;
            end
         end
         FN_CUT: begin
            priority if (!edge_ok) begin
               res_in.status = ST_RANGE;
            end else if (!inf_rd_ff) begin
               res_in.status = ST_UNLINKED;
            end
         end
         FN_CONTAINS: begin
            if (!edge_ok) begin
               res_in.status = ST_RANGE;
            end else begin
               res_in.is_present = inf_rd_ff;
            end
         end
         FN_FIRST, FN_NEXT: begin
            priority if ((req_ff.func == FN_FIRST) ? !node_ok : !slot_ok) begin
               res_in.status = ST_RANGE;
            end else if (ans_ptr[PW-1]) begin
               res_in.slot_none = 1'b1;
            end else begin
               res_in.slot_value = 8'(ans_ptr[SW-1:0]);
            end
         end
         FN_OTHER: begin
            if (!slot_ok) begin
               res_in.status = ST_RANGE;
            end else begin
               res_in.endpoint = req_ff.slot_index[0] ? 6'(tail_rd_ff) : 6'(head_rd_ff);
            end
         end
         default: begin
            res_in.status = ST_RANGE;
         end
      endcase
   end

   assign stat.clear_done = (clr_cnt_ff == CLW'(CLR_N - 1));
   assign stat.go_link    = (req_ff.func == FN_LINK) && (res_in.status == ST_OK);
   assign stat.go_cut     = (req_ff.func == FN_CUT) && (res_in.status == ST_OK);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   // memory port selection per step
   always_comb begin
      th_re  = 1'b0;
      th_we  = 1'b0;
      th_ra  = (req_ff.func == FN_OTHER) ? slot_edge : edge_a;
      inf_we = 1'b0;
      inf_wa = edge_a;
      inf_wd = 1'b0;
      lh_re  = 1'b0;
      lh_ra  = NW'(req_ff.node_index);
      lh_we  = 1'b0;
      lh_wa  = owner;
      lh_wd  = NONE_PTR;
      nx_re  = 1'b0;
      nx_ra  = SW'(req_ff.slot_index);
      nx_we  = 1'b0;
      nx_wa  = slot_cur;
      nx_wd  = NONE_PTR;
      pv_we  = 1'b0;
      pv_wa  = slot_cur;
      pv_wd  = NONE_PTR;
      unique case (cmd.op)
         OP_NOP, OP_LATCH, OP_RESULT: begin
         end
         OP_CLEAR: begin
            inf_we = clr_edge_ok;
            inf_wa = EW'(clr_cnt_ff);
            lh_we  = clr_node_ok;
            lh_wa  = NW'(clr_cnt_ff);
            nx_we  = clr_slot_ok;
            nx_wa  = SW'(clr_cnt_ff);
            pv_we  = clr_slot_ok;
            pv_wa  = SW'(clr_cnt_ff);
         end
         OP_READ: begin
            th_re = 1'b1;
            lh_re = 1'b1;
            nx_re = 1'b1;
         end
         OP_EVAL: begin
            th_we = define_ok;
         end
         OP_PUSH_RD: begin
            lh_re = 1'b1;
            lh_ra = owner;
         end
         OP_PUSH_WR: begin
            // new slot goes in front of the old first slot
            lh_we = 1'b1;
            lh_wd = slot_ptr;
            nx_we = 1'b1;
            nx_wd = lh_rd_ff;
            pv_we = 1'b1;
         end
         OP_PUSH_FIX: begin
            pv_we  = !lh_rd_ff[PW-1];
            pv_wa  = lh_rd_ff[SW-1:0];
            pv_wd  = slot_ptr;
            inf_we = cmd.sel;
            inf_wd = 1'b1;
         end
         OP_CUT_RD: begin
            nx_re = 1'b1;
            nx_ra = slot_cur;
         end
         OP_CUT_WR: begin
            // splice neighbors around the slot
            lh_we = pv_rd_ff[PW-1];
            lh_wd = nx_rd_ff;
            nx_we = !pv_rd_ff[PW-1];
            nx_wa = pv_rd_ff[SW-1:0];
            nx_wd = nx_rd_ff;
            pv_we = !nx_rd_ff[PW-1];
            pv_wa = nx_rd_ff[SW-1:0];
            pv_wd = pv_rd_ff;
         end
         OP_CUT_CLR: begin
            nx_we  = 1'b1;
            pv_we  = 1'b1;
            inf_we = cmd.sel;
         end
         default: begin
         end
      endcase
   end

   // edge endpoint tables
   always_ff @(posedge clock) begin
      if (th_we) begin
         tail_mem[edge_a] <= NW'(req_ff.tail_node);
         head_mem[edge_a] <= NW'(req_ff.head_node);
      end
      if (th_re) begin
         tail_rd_ff <= tail_mem[th_ra];
         head_rd_ff <= head_mem[th_ra];
      end
   end

   // membership flags
   always_ff @(posedge clock) begin
      if (inf_we) begin
         inf_mem[inf_wa] <= inf_wd;
      end
      if (th_re) begin
         inf_rd_ff <= inf_mem[edge_a];
      end
   end

   // list heads per node
   always_ff @(posedge clock) begin
      if (lh_we) begin
         lhead_mem[lh_wa] <= lh_wd;
      end
      if (lh_re) begin
         lh_rd_ff <= lhead_mem[lh_ra];
      end
   end

   // forward links per slot
   always_ff @(posedge clock) begin
      if (nx_we) begin
         next_mem[nx_wa] <= nx_wd;
      end
      if (nx_re) begin
         nx_rd_ff <= next_mem[nx_ra];
      end
   end

   // backward links per slot
   always_ff @(posedge clock) begin
      if (pv_we) begin
         prev_mem[pv_wa] <= pv_wd;
      end
      if (cmd.op == OP_CUT_RD) begin
         pv_rd_ff <= prev_mem[slot_cur];
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LATCH) begin
         req_ff <= req_payload;
      end
      if (cmd.op == OP_EVAL) begin
         res_ff <= res_in;
      end
      if (cmd.op == OP_RESULT) begin
         rsp_payload_ff <= res_ff;
      end
   end

   // control registers
   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      node_count_in = node_count_ff;
      edge_count_in = edge_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (cmd.op == OP_CLEAR && !stat.clear_done) begin
         clr_cnt_in = clr_cnt_ff + CLW'(1);
      end
      if (csr_valid && csr_index == CSR_NODE_COUNT) begin
         node_count_in = csr_data[6:0];
      end
      if (csr_valid && csr_index == CSR_EDGE_COUNT) begin
         edge_count_in = csr_data;
      end
      priority if (cmd.op == OP_RESULT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff    <= '0;
         node_count_ff <= NODE_COUNT_RST;
         edge_count_ff <= EDGE_COUNT_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_cnt_ff    <= clr_cnt_in;
         node_count_ff <= node_count_in;
         edge_count_ff <= edge_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: sv/dynamic_forest_adjacency_lists.sv
// dynamic_forest_adjacency_lists: top level of the forest adjacency list block.
// Depends on dfal_pkg, dfal_ctrl and dfal_datapath.
//
//   channel   ports                                direction  transfer when
//   request   req_valid req_ready req_payload      in         req_valid && req_ready
//   response  rsp_valid rsp_ready rsp_payload      out        rsp_valid && rsp_ready
//   csr       csr_valid csr_ready csr_index/data   in         csr_valid && csr_ready
//
// one request is worked at a time; its cost is set by the dependent read-then-write
// steps on the list memories: define, contains and the queries pass latch, read,
// check and result steps; link and cut add three memory steps per edge end slot
// after reset a clearing pass empties the lists and membership flags; req_ready stays
// low until it ends, csr writes are taken always
// a finished response sits in its own register, so a new request is taken while it
// waits; only a second finished response stalls behind an untaken one
module dynamic_forest_adjacency_lists
   import dfal_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES,
   parameter int MAX_EDGES = DEF_MAX_EDGES
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   // csr write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // csr registers are plain flops, every write lands at once
   assign csr_ready = 1'b1;

   // sequencer: clear pass, request latch, check, push or unlink steps, result load
   dfal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // tables, link memories, counts and response register
   dfal_datapath #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: sv/dfal_checker.sv
// dfal_assertions: port-level assertions for the forest adjacency list block, bound to
// the top level below. Depends on dfal_pkg.
module dfal_assertions
   import dfal_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // one request in flight: ready drops right after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // a response needs the read, check and result steps of work after its request
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response appeared one cycle after request transfer");

   // error responses carry no answer
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != ST_OK) |->
         !rsp_payload.is_present && (rsp_payload.slot_value == 8'd0)
         && !rsp_payload.slot_none && (rsp_payload.endpoint == 6'd0))
      else $error("error response with nonzero answer fields");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed or dropped");

endmodule

bind dynamic_forest_adjacency_lists dfal_assertions u_dfal_assertions (.*);

// File: sim/dfal_checker.sv
// dfal_checker: watches the request, response and csr channels of the forest adjacency
// list block, keeps its own copy of the edge table and slot lists, and checks every response
// depends on dfal_pkg for the payload types, function codes and status codes
module dfal_checker
   import dfal_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_payload_type       req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_payload_type       rsp_payload,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending
);

   localparam int NODE_SPAN = DEF_MAX_NODES;
   localparam int EDGE_SPAN = DEF_MAX_EDGES;
   localparam int SLOT_SPAN = 2 * DEF_MAX_EDGES;
   localparam logic [8:0] NO_LINK = 9'h1FF;

   logic [5:0] tail_of  [EDGE_SPAN];
   logic [5:0] head_of  [EDGE_SPAN];
   logic       linked   [EDGE_SPAN];
   logic [8:0] first_of [NODE_SPAN];
   logic [8:0] next_of  [SLOT_SPAN];
   logic [8:0] prev_of  [SLOT_SPAN];
   logic [6:0] node_cfg;
   logic [7:0] edge_cfg;

   rsp_payload_type forest_answers [$];
   int mismatches = 0;

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic logic [5:0] slot_node(input logic [7:0] slot);
      return slot[0] ? head_of[slot[7:1]] : tail_of[slot[7:1]];
   endfunction

   function automatic void push_slot(input logic [7:0] slot);
      logic [5:0] node;
      logic [8:0] old;
      node = slot_node(slot);
      old = first_of[node];
      prev_of[slot] = NO_LINK;
      next_of[slot] = old;
      if (old != NO_LINK)
         prev_of[old[7:0]] = {1'b0, slot};
      first_of[node] = {1'b0, slot};
   endfunction

   function automatic void pull_slot(input logic [7:0] slot);
      logic [5:0] node;
      logic [8:0] pred;
      logic [8:0] succ;
      node = slot_node(slot);
      pred = prev_of[slot];
      succ = next_of[slot];
      if (pred == NO_LINK)
         first_of[node] = succ;
      else
         next_of[pred[7:0]] = succ;
      if (succ != NO_LINK)
         prev_of[succ[7:0]] = pred;
      next_of[slot] = NO_LINK;
      prev_of[slot] = NO_LINK;
   endfunction

   // applies one request to the local lists and returns the response it must give
   function automatic rsp_payload_type forest_answer(input req_payload_type rq);
      rsp_payload_type ans;
      int nn;
      int ne;
      logic [8:0] hit;
      logic asks_slot;
      ans = '0;
      hit = NO_LINK;
      asks_slot = 1'b0;
      nn = (node_cfg < NODE_SPAN) ? int'(node_cfg) : NODE_SPAN;
      ne = (edge_cfg < EDGE_SPAN) ? int'(edge_cfg) : EDGE_SPAN;
      case (rq.func)
         FN_DEFINE: begin
            if (rq.edge_index >= ne)
               ans.status = ST_RANGE;
            else if (rq.tail_node >= nn || rq.head_node >= nn || rq.tail_node == rq.head_node)
               ans.status = ST_BADEDGE;
            else if (linked[rq.edge_index])
               ans.status = ST_LINKED;
            else begin
               tail_of[rq.edge_index] = rq.tail_node;
               head_of[rq.edge_index] = rq.head_node;
            end
         end
         FN_LINK: begin
            if (rq.edge_index >= ne)
               ans.status = ST_RANGE;
            else if (linked[rq.edge_index])
               ans.status = ST_LINKED;
            else begin
               push_slot({rq.edge_index, 1'b0});
               push_slot({rq.edge_index, 1'b1});
               linked[rq.edge_index] = 1'b1;
            end
         end
         FN_CUT: begin
            if (rq.edge_index >= ne)
               ans.status = ST_RANGE;
            else if (!linked[rq.edge_index])
               ans.status = ST_UNLINKED;
            else begin
               pull_slot({rq.edge_index, 1'b0});
               pull_slot({rq.edge_index, 1'b1});
               linked[rq.edge_index] = 1'b0;
            end
         end
         FN_CONTAINS: begin
            if (rq.edge_index >= ne)
               ans.status = ST_RANGE;
            else
               ans.is_present = linked[rq.edge_index];
         end
         FN_FIRST: begin
            if (rq.node_index >= nn)
               ans.status = ST_RANGE;
            else begin
               hit = first_of[rq.node_index];
               asks_slot = 1'b1;
            end
         end
         FN_NEXT: begin
            if (rq.slot_index >= 2 * ne)
               ans.status = ST_RANGE;
            else begin
               hit = next_of[rq.slot_index];
               asks_slot = 1'b1;
            end
         end
         FN_OTHER: begin
            if (rq.slot_index >= 2 * ne)
               ans.status = ST_RANGE;
            else
               ans.endpoint = rq.slot_index[0] ? tail_of[rq.slot_index[7:1]]
                                               : head_of[rq.slot_index[7:1]];
         end
         default: ans.status = ST_RANGE;
      endcase
      if (asks_slot) begin
         if (hit == NO_LINK)
            ans.slot_none = 1'b1;
         else
            ans.slot_value = hit[7:0];
      end
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (reset) begin
         for (int i = 0; i < EDGE_SPAN; i++)
            linked[i] = 1'b0;
         for (int i = 0; i < NODE_SPAN; i++)
            first_of[i] = NO_LINK;
         for (int i = 0; i < SLOT_SPAN; i++) begin
            next_of[i] = NO_LINK;
            prev_of[i] = NO_LINK;
         end
         node_cfg = NODE_COUNT_RST;
         edge_cfg = EDGE_COUNT_RST;
         forest_answers.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_NODE_COUNT)
               node_cfg = csr_data[6:0];
            else if (csr_index == CSR_EDGE_COUNT)
               edge_cfg = csr_data;
         end
         // responses first: one accepted at this edge cannot belong to a request taken now
         if (rsp_valid && rsp_ready) begin
            if (forest_answers.size() == 0)
               report_mismatch("response transfer with nothing outstanding");
            else begin
               want = forest_answers.pop_front();
               if (rsp_payload.status !== want.status)
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_payload.status, want.status));
               if (rsp_payload.is_present !== want.is_present)
                  report_mismatch($sformatf("is_present got %0b expected %0b",
                                            rsp_payload.is_present, want.is_present));
               if (rsp_payload.slot_value !== want.slot_value)
                  report_mismatch($sformatf("slot_value got %0d expected %0d",
                                            rsp_payload.slot_value, want.slot_value));
               if (rsp_payload.slot_none !== want.slot_none)
                  report_mismatch($sformatf("slot_none got %0b expected %0b",
                                            rsp_payload.slot_none, want.slot_none));
               if (rsp_payload.endpoint !== want.endpoint)
                  report_mismatch($sformatf("endpoint got %0d expected %0d",
                                            rsp_payload.endpoint, want.endpoint));
            end
         end
         if (req_valid && req_ready)
            forest_answers.push_back(forest_answer(req_payload));
      end
      fail_count <= mismatches;
      pending <= forest_answers.size();
   end

endmodule

// File: sim/tb.sv
// tb: top of the forest adjacency list testbench; drives requests, csr writes and
// response back-pressure, and gives the verdict
// depends on dfal_pkg, dynamic_forest_adjacency_lists and dfal_checker
module tb;
   import dfal_pkg::*;

   localparam int IDLE_LIMIT    = 4000;  // clearing pass, long hold-off and gaps fit many times
   localparam int SETTLE_CYCLES = 24;    // outlasts a link or cut request
   localparam int HOLD_AT       = 60;    // response count at which the long hold-off starts
   localparam int HOLD_CYCLES   = 300;
   localparam logic [2:0] FN_UNUSED = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 4'd9;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_ready;
   rsp_payload_type rsp_payload;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int fail_count;
   int pending;
   int quiet_cycles = 0;

   // idle draw limits for each side, changed per phase
   int send_gap_max = 4;
   int rsp_gap_max = 4;

   // stimulus-side view of the counts and of which edges hold endpoints
   int node_lim = DEF_MAX_NODES;
   int edge_lim = DEF_MAX_EDGES;
   bit defined_edge [DEF_MAX_EDGES];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dynamic_forest_adjacency_lists dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   dfal_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // watchdog: any transfer restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response side: random low stretches per transfer, plus one long hold-off
   // so the block fills up and pushes back on requests
   initial begin : receiver
      int wait_left;
      int taken;
      wait_left = 0;
      taken = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            wait_left = 0;
         end else if (rsp_valid && rsp_ready) begin
            taken++;
            wait_left = $urandom_range(0, rsp_gap_max);
            if (taken == HOLD_AT)
               wait_left = HOLD_CYCLES;
         end else if (wait_left > 0) begin
            wait_left--;
         end
         rsp_ready <= !reset && wait_left == 0;
      end
   end

   function automatic req_payload_type forest_op(input logic [2:0] fn, input int e,
                                                 input int t, input int h, input int n,
                                                 input int s);
      req_payload_type p;
      p.func = fn;
      p.edge_index = 7'(e);
      p.tail_node = 6'(t);
      p.head_node = 6'(h);
      p.node_index = 6'(n);
      p.slot_index = 8'(s);
      return p;
   endfunction

   // one request transfer; valid stays up across back-to-back items
   task automatic offer(input req_payload_type p);
      int gap;
      if (p.func == FN_DEFINE && p.edge_index < edge_lim && p.tail_node < node_lim &&
          p.head_node < node_lim && p.tail_node != p.head_node)
         defined_edge[p.edge_index] = 1'b1;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= p;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // csr valid is left high so writes can go back to back; caller lowers it
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_counts(input logic [7:0] nodes, input logic [7:0] edges);
      csr_write(CSR_NODE_COUNT, nodes);
      csr_write(CSR_EDGE_COUNT, edges);
      csr_valid <= 1'b0;
      node_lim = (nodes[6:0] < DEF_MAX_NODES) ? int'(nodes[6:0]) : DEF_MAX_NODES;
      edge_lim = (edges < DEF_MAX_EDGES) ? int'(edges) : DEF_MAX_EDGES;
   endtask

   // wait for every outstanding response, then let the block settle
   task automatic drain_block;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly in-range indices so edges get defined, linked and cut into long lists;
   // a link or far-endpoint ask on an edge with no endpoints becomes a define (a contains if under two nodes)
   task automatic random_ops(input int count);
      req_payload_type p;
      int r;
      logic [6:0] e;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 18)      p.func = FN_DEFINE;
         else if (r < 42) p.func = FN_LINK;
         else if (r < 58) p.func = FN_CUT;
         else if (r < 66) p.func = FN_CONTAINS;
         else if (r < 76) p.func = FN_FIRST;
         else if (r < 88) p.func = FN_NEXT;
         else if (r < 97) p.func = FN_OTHER;
         else             p.func = FN_UNUSED;
         p.edge_index = 7'($urandom());
         p.tail_node = 6'($urandom());
         p.head_node = 6'($urandom());
         p.node_index = 6'($urandom());
         p.slot_index = 8'($urandom());
         if ($urandom_range(0, 99) < 85) begin
            if (edge_lim > 0) begin
               p.edge_index = 7'($urandom_range(0, edge_lim - 1));
               p.slot_index = 8'($urandom_range(0, 2 * edge_lim - 1));
            end
            if (node_lim > 0) begin
               p.tail_node = 6'($urandom_range(0, node_lim - 1));
               p.head_node = 6'($urandom_range(0, node_lim - 1));
               p.node_index = 6'($urandom_range(0, node_lim - 1));
            end
         end
         e = (p.func == FN_OTHER) ? p.slot_index[7:1] : p.edge_index;
         if (((p.func == FN_LINK && p.edge_index < edge_lim) ||
              (p.func == FN_OTHER && p.slot_index < 2 * edge_lim)) && !defined_edge[e]) begin
            if (node_lim >= 2) begin
               p.func = FN_DEFINE;
               p.edge_index = e;
               p.tail_node = 6'($urandom_range(0, node_lim - 1));
               p.head_node = 6'((int'(p.tail_node) + 1 + int'($urandom_range(0, node_lim - 2)))
                                % node_lim);
            end else begin
               p.func = FN_CONTAINS;
            end
         end
         offer(p);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty lists, extremes of the tables, double link and cut,
      // define on a linked edge, self loop, list walk, unknown function
      offer(forest_op(FN_CONTAINS, 0, 0, 0, 0, 0));
      offer(forest_op(FN_CONTAINS, 127, 0, 0, 0, 0));
      offer(forest_op(FN_FIRST, 0, 0, 0, 0, 0));
      offer(forest_op(FN_NEXT, 0, 0, 0, 0, 0));
      offer(forest_op(FN_DEFINE, 0, 0, 63, 0, 0));
      offer(forest_op(FN_DEFINE, 127, 63, 1, 0, 0));
      offer(forest_op(FN_DEFINE, 1, 5, 5, 0, 0));
      offer(forest_op(FN_LINK, 0, 0, 0, 0, 0));
      offer(forest_op(FN_LINK, 0, 0, 0, 0, 0));
      offer(forest_op(FN_DEFINE, 0, 1, 2, 0, 0));
      offer(forest_op(FN_LINK, 127, 0, 0, 0, 0));
      offer(forest_op(FN_CONTAINS, 0, 0, 0, 0, 0));
      offer(forest_op(FN_FIRST, 0, 0, 0, 63, 0));
      offer(forest_op(FN_NEXT, 0, 0, 0, 0, 254));
      offer(forest_op(FN_NEXT, 0, 0, 0, 0, 1));
      offer(forest_op(FN_OTHER, 0, 0, 0, 0, 0));
      offer(forest_op(FN_OTHER, 0, 0, 0, 0, 255));
      offer(forest_op(FN_CUT, 0, 0, 0, 0, 0));
      offer(forest_op(FN_CUT, 0, 0, 0, 0, 0));
      offer(forest_op(FN_FIRST, 0, 0, 0, 63, 0));
      offer(forest_op(FN_NEXT, 0, 0, 0, 0, 254));
      offer(forest_op(FN_FIRST, 0, 0, 0, 0, 0));
      offer(forest_op(FN_UNUSED, 127, 63, 63, 63, 255));
      offer(forest_op(FN_DEFINE, 2, 62, 63, 0, 0));
      drain_block();

      // few nodes, moderate edges: deep lists, cuts from the middle; long hold-off lands here
      set_counts(8'd5, 8'd16);
      random_ops(150);
      drain_block();

      // shrunk counts hide linked edges; no idling on either side
      send_gap_max = 0;
      rsp_gap_max = 0;
      set_counts(8'd3, 8'd6);
      random_ops(70);
      drain_block();

      // zero counts: everything out of range; unknown csr index is ignored
      send_gap_max = 4;
      rsp_gap_max = 4;
      csr_write(CSR_UNUSED, 8'hA5);
      set_counts(8'd0, 8'd0);
      random_ops(12);
      drain_block();

      // counts above the table sizes clamp to full size
      set_counts(8'hFF, 8'hFF);
      random_ops(180);
      drain_block();

      // smallest usable setting
      set_counts(8'd2, 8'd1);
      random_ops(20);
      drain_block();

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
